@@ rtl/link_watchdog_safety_monitor_top_defines.svh @@
// ----------------------------------------------------------------------------
// Link watchdog safety monitor: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LINK_WATCHDOG_SAFETY_MONITOR_TOP_DEFINES_SVH
`define LINK_WATCHDOG_SAFETY_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define LWSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LWSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lwsm_pkg.sv @@
// ----------------------------------------------------------------------------
// lwsm_pkg
// Types and codes shared by the link watchdog safety monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwsm_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned TmoW    = 16;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned IdW     = 3;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  localparam logic [TmoW-1:0]  MotorTmoReset = 16'd500;
  localparam logic [TmoW-1:0]  HostTmoReset  = 16'd1000;
  localparam logic [TimeW-1:0] AgeNever      = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_CHECK    = 2'd0,
    OP_MOTOR_RX = 2'd1,
    OP_HOST_ACT = 2'd2,
    OP_HOST_HB  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_MANUAL     = 2'd0,
    MODE_AUTONOMOUS = 2'd1,
    MODE_DISARM     = 2'd2,
    MODE_OTHER      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_DISARM    = 2'd1,
    ACT_STALE     = 2'd2,
    ACT_NO_ACTION = 2'd3
  } act_e;

  // register index is paddr[2]
  typedef enum logic {
    REG_MOTOR_TMO = 1'b0,
    REG_HOST_TMO  = 1'b1
  } reg_e;

  typedef struct packed {
    logic [TmoW-1:0] motor_tmo;
    logic [TmoW-1:0] host_tmo;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [TimeW-1:0] now_ms;
    logic [IdW-1:0]   motor_id;
    logic [1:0]       run_mode;
  } in_item_t;

  typedef struct packed {
    logic [MaskW-1:0] lost_mask;
    logic [MaskW-1:0] newly_lost_mask;
    logic [MaskW-1:0] recovered_mask;
    logic             host_seen;
    logic             host_alive;
    logic             host_timeout_latched;
    logic [1:0]       host_timeout_action;
    logic             host_recovered;
    logic             heartbeat_fresh;
    logic [TimeW-1:0] host_link_age_ms;
  } out_item_t;

endpackage

@@ rtl/lwsm_if.sv @@
// ----------------------------------------------------------------------------
// lwsm_in_if / lwsm_out_if
// Valid/ready channels carrying event items and status items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lwsm_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [lwsm_pkg::TimeW-1:0]   now_ms;
  logic [lwsm_pkg::IdW-1:0]     motor_id;
  logic [1:0]                   run_mode;

  modport source (output valid, opcode, now_ms, motor_id, run_mode, input ready);
  modport sink   (input valid, opcode, now_ms, motor_id, run_mode, output ready);
endinterface

interface lwsm_out_if;
  logic                         valid;
  logic                         ready;
  logic [lwsm_pkg::MaskW-1:0]   lost_mask;
  logic [lwsm_pkg::MaskW-1:0]   newly_lost_mask;
  logic [lwsm_pkg::MaskW-1:0]   recovered_mask;
  logic                         host_seen;
  logic                         host_alive;
  logic                         host_timeout_latched;
  logic [1:0]                   host_timeout_action;
  logic                         host_recovered;
  logic                         heartbeat_fresh;
  logic [lwsm_pkg::TimeW-1:0]   host_link_age_ms;

  modport source (output valid, lost_mask, newly_lost_mask, recovered_mask, host_seen,
                  host_alive, host_timeout_latched, host_timeout_action, host_recovered,
                  heartbeat_fresh, host_link_age_ms, input ready);
  modport sink   (input valid, lost_mask, newly_lost_mask, recovered_mask, host_seen,
                  host_alive, host_timeout_latched, host_timeout_action, host_recovered,
                  heartbeat_fresh, host_link_age_ms, output ready);
endinterface

@@ rtl/lwsm_cfg.sv @@
// ----------------------------------------------------------------------------
// lwsm_cfg
// APB register file holding the motor and host link timeouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwsm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lwsm_pkg::PaddrW-1:0]   paddr,
  input  logic [lwsm_pkg::PdataW-1:0]   pwdata,
  output logic [lwsm_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output lwsm_pkg::cfg_t                cfg_o
);

  logic [lwsm_pkg::TmoW-1:0] motor_tmo_q;
  logic [lwsm_pkg::TmoW-1:0] host_tmo_q;
  logic                      wr_en;
  lwsm_pkg::reg_e            reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = lwsm_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_tmo_q <= lwsm_pkg::MotorTmoReset;
      host_tmo_q  <= lwsm_pkg::HostTmoReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        lwsm_pkg::REG_MOTOR_TMO: motor_tmo_q <= pwdata[lwsm_pkg::TmoW-1:0];
        lwsm_pkg::REG_HOST_TMO:  host_tmo_q  <= pwdata[lwsm_pkg::TmoW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lwsm_pkg::REG_MOTOR_TMO: prdata = {16'd0, motor_tmo_q};
      lwsm_pkg::REG_HOST_TMO:  prdata = {16'd0, host_tmo_q};
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.motor_tmo = motor_tmo_q;
  assign cfg_o.host_tmo  = host_tmo_q;

endmodule

@@ rtl/lwsm_core.sv @@
// ----------------------------------------------------------------------------
// lwsm_core
// Watchdog state and the single-pass update for one event item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "link_watchdog_safety_monitor_top_defines.svh"

module lwsm_core #(
  parameter int unsigned MOTOR_SLOTS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  lwsm_pkg::in_item_t   item_i,
  input  lwsm_pkg::cfg_t       cfg_i,
  output lwsm_pkg::out_item_t  res_o
);

  logic [lwsm_pkg::TimeW-1:0] rx_time_q [MOTOR_SLOTS];
  logic [lwsm_pkg::TimeW-1:0] rx_time_d [MOTOR_SLOTS];
  logic [MOTOR_SLOTS-1:0]     lost_q, lost_d;
  logic [MOTOR_SLOTS-1:0]     recov_q, recov_d;
  logic [lwsm_pkg::TimeW-1:0] act_time_q, act_time_d;
  logic [lwsm_pkg::TimeW-1:0] hb_time_q, hb_time_d;
  logic                       seen_q, seen_d;
  logic                       alive_q, alive_d;
  logic                       latched_q, latched_d;
  logic                       hrecov_q, hrecov_d;
  logic                       hb_seen_q, hb_seen_d;

  lwsm_pkg::op_e              op;
  logic [lwsm_pkg::TimeW-1:0] now;
  logic [lwsm_pkg::TimeW-1:0] motor_tmo32;
  logic [lwsm_pkg::TimeW-1:0] host_tmo32;

  assign op          = lwsm_pkg::op_e'(item_i.opcode);
  assign now         = item_i.now_ms;
  assign motor_tmo32 = {16'd0, cfg_i.motor_tmo};
  assign host_tmo32  = {16'd0, cfg_i.host_tmo};

  always_comb begin
    logic [lwsm_pkg::TimeW-1:0] motor_age;
    logic [lwsm_pkg::MaskW-1:0] newly;
    logic [lwsm_pkg::MaskW-1:0] recovered;
    logic [lwsm_pkg::MaskW-1:0] lost_mask;
    lwsm_pkg::act_e             action;
    logic                       host_rec;
    logic                       touch;

    rx_time_d  = rx_time_q;
    lost_d     = lost_q;
    recov_d    = recov_q;
    act_time_d = act_time_q;
    hb_time_d  = hb_time_q;
    seen_d     = seen_q;
    alive_d    = alive_q;
    latched_d  = latched_q;
    hrecov_d   = hrecov_q;
    hb_seen_d  = hb_seen_q;
    newly      = '0;
    recovered  = '0;
    lost_mask  = '0;
    action     = lwsm_pkg::ACT_NONE;
    host_rec   = 1'b0;
    touch      = 1'b0;
    motor_age  = '0;

    unique case (op)
      lwsm_pkg::OP_CHECK: begin
        for (int i = 0; i < int'(MOTOR_SLOTS); i++) begin
          motor_age = now - rx_time_q[i];
          // stored time of zero: motor never heard
          if (rx_time_q[i] != '0 && motor_age >= motor_tmo32 && !lost_q[i]) begin
            lost_d[i] = 1'b1;
            newly[i]  = 1'b1;
          end
          recovered[i] = recov_q[i];
        end
        recov_d = '0;
        if (seen_q && alive_q && !latched_q && (now - act_time_q) >= host_tmo32) begin
          latched_d = 1'b1;
          alive_d   = 1'b0;
          priority if (item_i.run_mode == lwsm_pkg::MODE_MANUAL) begin
            action = lwsm_pkg::ACT_DISARM;
          end else if (item_i.run_mode == lwsm_pkg::MODE_AUTONOMOUS) begin
            action = lwsm_pkg::ACT_STALE;
          end else begin
            action = lwsm_pkg::ACT_NO_ACTION;
          end
        end
        host_rec = hrecov_q;
        hrecov_d = 1'b0;
      end
      lwsm_pkg::OP_MOTOR_RX: begin
        // ids at or above the slot count match no slot
        for (int i = 0; i < int'(MOTOR_SLOTS); i++) begin
          if (int'(item_i.motor_id) == i) begin
            if (lost_q[i]) recov_d[i] = 1'b1;
            rx_time_d[i] = now;
            lost_d[i]    = 1'b0;
          end
        end
      end
      lwsm_pkg::OP_HOST_ACT: touch = 1'b1;
      lwsm_pkg::OP_HOST_HB: begin
        touch     = 1'b1;
        hb_time_d = now;
        hb_seen_d = 1'b1;
      end
      default: ;
    endcase

    if (touch) begin
      if (latched_q || (seen_q && !alive_q)) hrecov_d = 1'b1;
      act_time_d = now;
      seen_d     = 1'b1;
      alive_d    = 1'b1;
      latched_d  = 1'b0;
    end

    for (int i = 0; i < int'(MOTOR_SLOTS); i++) begin
      lost_mask[i] = lost_d[i];
    end

    res_o.lost_mask            = lost_mask;
    res_o.newly_lost_mask      = newly;
    res_o.recovered_mask       = recovered;
    res_o.host_seen            = seen_d;
    res_o.host_alive           = alive_d;
    res_o.host_timeout_latched = latched_d;
    res_o.host_timeout_action  = action;
    res_o.host_recovered       = host_rec;
    res_o.heartbeat_fresh      = hb_seen_d && ((now - hb_time_d) < host_tmo32);
    res_o.host_link_age_ms     = (act_time_d == '0) ? lwsm_pkg::AgeNever : (now - act_time_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MOTOR_SLOTS); i++) begin
        rx_time_q[i] <= '0;
      end
      lost_q     <= '0;
      recov_q    <= '0;
      act_time_q <= '0;
      hb_time_q  <= '0;
      seen_q     <= 1'b0;
      alive_q    <= 1'b0;
      latched_q  <= 1'b0;
      hrecov_q   <= 1'b0;
      hb_seen_q  <= 1'b0;
    end else if (adv_i) begin
      rx_time_q  <= rx_time_d;
      lost_q     <= lost_d;
      recov_q    <= recov_d;
      act_time_q <= act_time_d;
      hb_time_q  <= hb_time_d;
      seen_q     <= seen_d;
      alive_q    <= alive_d;
      latched_q  <= latched_d;
      hrecov_q   <= hrecov_d;
      hb_seen_q  <= hb_seen_d;
    end
  end

  `LWSM_ASSERT_IMPL(a_newly_in_lost, adv_i, (res_o.newly_lost_mask & ~res_o.lost_mask) == '0, "newly lost motor missing from lost mask")
  `LWSM_ASSERT_IMPL(a_event_quiet, adv_i && op != lwsm_pkg::OP_CHECK, res_o.newly_lost_mask == '0 && res_o.recovered_mask == '0 && res_o.host_timeout_action == lwsm_pkg::ACT_NONE && !res_o.host_recovered, "check-only fields set on an event item")
  `LWSM_ASSERT_IMPL(a_action_latches, adv_i && res_o.host_timeout_action != lwsm_pkg::ACT_NONE, res_o.host_timeout_latched && !res_o.host_alive, "host timeout action without latch")
  `LWSM_ASSERT_NEXT(a_check_clears_recov, adv_i && op == lwsm_pkg::OP_CHECK, recov_q == '0 && !hrecov_q, "pending recovery survived a check")

endmodule

@@ rtl/link_watchdog_safety_monitor_top.sv @@
// ----------------------------------------------------------------------------
// link_watchdog_safety_monitor_top
// Motor and host link watchdog with APB-programmed timeouts.
//
//   channel  dir  handshake        carries
//   in_i     in   valid/ready      opcode, now_ms, motor_id, run_mode
//   out_o    out  valid/ready      masks, host flags, action, freshness, age
//   apb      in   psel/penable     timeout registers at 0x0 and 0x4
//
// One item per cycle sustained while out_o is not stalled.
// The input register feeds one pass of compare logic (one subtract-compare per
// motor slot plus two for the host) that updates state and loads the result register.
// Reset clears all link state; timeouts return to 500 ms and 1000 ms.
// A stall on out_o holds the result register and, once the input register is full,
// lowers in_i.ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_watchdog_safety_monitor_top #(
  parameter int unsigned MOTOR_SLOTS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lwsm_in_if.sink                       in_i,
  lwsm_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lwsm_pkg::PaddrW-1:0]   paddr,
  input  logic [lwsm_pkg::PdataW-1:0]   pwdata,
  output logic [lwsm_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  lwsm_pkg::cfg_t      cfg;
  lwsm_pkg::in_item_t  in_q;
  logic                in_valid_q;
  lwsm_pkg::out_item_t res;
  lwsm_pkg::out_item_t out_q;
  logic                out_valid_q;
  logic                adv;

  // item moves from the input register into the result register
  assign adv        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (adv) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.opcode   <= in_i.opcode;
      in_q.now_ms   <= in_i.now_ms;
      in_q.motor_id <= in_i.motor_id;
      in_q.run_mode <= in_i.run_mode;
    end
    if (adv) out_q <= res;
  end

  lwsm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lwsm_core #(
    .MOTOR_SLOTS (MOTOR_SLOTS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_o.valid                = out_valid_q;
  assign out_o.lost_mask            = out_q.lost_mask;
  assign out_o.newly_lost_mask      = out_q.newly_lost_mask;
  assign out_o.recovered_mask       = out_q.recovered_mask;
  assign out_o.host_seen            = out_q.host_seen;
  assign out_o.host_alive           = out_q.host_alive;
  assign out_o.host_timeout_latched = out_q.host_timeout_latched;
  assign out_o.host_timeout_action  = out_q.host_timeout_action;
  assign out_o.host_recovered       = out_q.host_recovered;
  assign out_o.heartbeat_fresh      = out_q.heartbeat_fresh;
  assign out_o.host_link_age_ms     = out_q.host_link_age_ms;

endmodule
